// ----- rtl/vdcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdcd_pkg: shared types and constants of the vector draw command decoder
// Command classes, tool codes, draw operation codes and the word formats
// that pass between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package vdcd_pkg;

  // fixed widths of the result ports
  localparam int OUT_CW = 16;
  localparam int OUT_VW = 32;

  // command byte layout
  localparam int CMD_W  = 8;
  localparam int OPND_W = 6;

  // opcodes in bits 7..6
  typedef enum logic [1:0] {
    OPC_DX   = 2'd0,
    OPC_DY   = 2'd1,
    OPC_TOOL = 2'd2,
    OPC_DATA = 2'd3
  } opc_t;

  // tool codes
  localparam logic [OPND_W-1:0] TOOL_NONE    = 6'd0;
  localparam logic [OPND_W-1:0] TOOL_LINE    = 6'd1;
  localparam logic [OPND_W-1:0] TOOL_BLOCK   = 6'd2;
  localparam logic [OPND_W-1:0] TOOL_COLOUR  = 6'd3;
  localparam logic [OPND_W-1:0] TOOL_TARGETX = 6'd4;
  localparam logic [OPND_W-1:0] TOOL_TARGETY = 6'd5;
  localparam logic [OPND_W-1:0] TOOL_SHOW    = 6'd6;
  localparam logic [OPND_W-1:0] TOOL_PAUSE   = 6'd7;
  localparam logic [OPND_W-1:0] TOOL_EOF     = 6'd8;

  // draw operation codes on the result port
  localparam logic [2:0] DOP_LINE   = 3'd0;
  localparam logic [2:0] DOP_BLOCK  = 3'd1;
  localparam logic [2:0] DOP_COLOUR = 3'd2;
  localparam logic [2:0] DOP_SHOW   = 3'd3;
  localparam logic [2:0] DOP_PAUSE  = 3'd4;
  localparam logic [2:0] DOP_EOF    = 3'd5;

  // action class assigned by the front end
  typedef enum logic [3:0] {
    ACT_DX,
    ACT_DY,
    ACT_DATA,
    ACT_COLOUR,
    ACT_TGTX,
    ACT_TGTY,
    ACT_SHOW,
    ACT_PAUSE,
    ACT_EOF,
    ACT_SELTOOL
  } act_t;

  // classified command word
  typedef struct packed {
    act_t              act;
    logic [OPND_W-1:0] opnd;
  } cmd_t;

  // result word
  typedef struct packed {
    logic [2:0]        draw_op;
    logic [OUT_CW-1:0] from_x;
    logic [OUT_CW-1:0] from_y;
    logic [OUT_CW-1:0] to_or_width;
    logic [OUT_CW-1:0] to_or_height;
    logic [OUT_VW-1:0] value;
  } res_t;

endpackage

// ----- rtl/vdcd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdcd_front: command byte classifier
// Qualifies the input handshake and splits each byte into an action class
// and its six-bit operand for the command queue.
// ----------------------------------------------------------------------------
module vdcd_front (
  input  logic                      push,
  input  logic                      q_full,
  input  logic [vdcd_pkg::CMD_W-1:0] cmd_byte,
  output logic                      q_push,
  output vdcd_pkg::cmd_t            q_word
);

  vdcd_pkg::opc_t opc;
  logic [vdcd_pkg::OPND_W-1:0] opnd;

  assign opc    = vdcd_pkg::opc_t'(cmd_byte[7:6]);
  assign opnd   = cmd_byte[vdcd_pkg::OPND_W-1:0];
  assign q_push = push && !q_full;

  // classify by opcode, and tool commands by operand
  always_comb begin
    q_word.opnd = opnd;
    q_word.act  = vdcd_pkg::ACT_DX;
    unique case (opc)
      vdcd_pkg::OPC_DX:   q_word.act = vdcd_pkg::ACT_DX;
      vdcd_pkg::OPC_DY:   q_word.act = vdcd_pkg::ACT_DY;
      vdcd_pkg::OPC_DATA: q_word.act = vdcd_pkg::ACT_DATA;
      vdcd_pkg::OPC_TOOL: begin
        if (opnd == vdcd_pkg::TOOL_COLOUR)       q_word.act = vdcd_pkg::ACT_COLOUR;
        else if (opnd == vdcd_pkg::TOOL_TARGETX) q_word.act = vdcd_pkg::ACT_TGTX;
        else if (opnd == vdcd_pkg::TOOL_TARGETY) q_word.act = vdcd_pkg::ACT_TGTY;
        else if (opnd == vdcd_pkg::TOOL_SHOW)    q_word.act = vdcd_pkg::ACT_SHOW;
        else if (opnd == vdcd_pkg::TOOL_PAUSE)   q_word.act = vdcd_pkg::ACT_PAUSE;
        else if (opnd == vdcd_pkg::TOOL_EOF)     q_word.act = vdcd_pkg::ACT_EOF;
        else                                     q_word.act = vdcd_pkg::ACT_SELTOOL;
      end
      default: q_word.act = vdcd_pkg::ACT_DX;
    endcase
  end

endmodule

// ----- rtl/vdcd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdcd_queue: small register queue
// First-in first-out buffer of DEPTH words with a fill count; the head word
// is presented while the queue is not empty.
// ----------------------------------------------------------------------------
module vdcd_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd)      cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/vdcd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdcd_back: command executor
// Holds pen, target, tool and data accumulator, carries out one classified
// command per cycle unless stalled, and writes any draw word to the result queue.
// ----------------------------------------------------------------------------
module vdcd_back #(
  parameter int COORD_WIDTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  vdcd_pkg::cmd_t cmd,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output vdcd_pkg::res_t res
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = DATA_WIDTH;
  localparam int OW = vdcd_pkg::OPND_W;

  logic [CW-1:0] pen_x_r, pen_x_nxt;
  logic [CW-1:0] pen_y_r, pen_y_nxt;
  logic [CW-1:0] tgt_x_r, tgt_x_nxt;
  logic [CW-1:0] tgt_y_r, tgt_y_nxt;
  logic [OW-1:0] tool_r, tool_nxt;
  logic [DW-1:0] accum_r, accum_nxt;

  logic [CW-1:0] sop;
  logic [CW-1:0] ty_sum;
  logic [CW-1:0] acc_coord;
  logic [vdcd_pkg::OUT_VW-1:0] acc_value;
  logic [CW+vdcd_pkg::OUT_CW-1:0] ext_px, ext_py, ext_tx, ext_ty, ext_w, ext_h;
  logic [DW+vdcd_pkg::OUT_VW-1:0] ext_acc;
  logic [DW+CW-1:0] ext_acc_c;

  assign cmd_pop = !cmd_empty && !res_full;

  // operand sign extension and sums
  assign sop    = {{(CW-OW){cmd.opnd[OW-1]}}, cmd.opnd};
  assign ty_sum = tgt_y_r + sop;

  // resize to port widths: zero-extend or keep the low bits
  assign ext_px    = {{vdcd_pkg::OUT_CW{1'b0}}, pen_x_r};
  assign ext_py    = {{vdcd_pkg::OUT_CW{1'b0}}, pen_y_r};
  assign ext_tx    = {{vdcd_pkg::OUT_CW{1'b0}}, tgt_x_r};
  assign ext_ty    = {{vdcd_pkg::OUT_CW{1'b0}}, ty_sum};
  assign ext_w     = {{vdcd_pkg::OUT_CW{1'b0}}, CW'(tgt_x_r - pen_x_r)};
  assign ext_h     = {{vdcd_pkg::OUT_CW{1'b0}}, CW'(ty_sum - pen_y_r)};
  assign ext_acc   = {{vdcd_pkg::OUT_VW{1'b0}}, accum_r};
  assign ext_acc_c = {{CW{1'b0}}, accum_r};
  assign acc_value = ext_acc[vdcd_pkg::OUT_VW-1:0];
  assign acc_coord = ext_acc_c[CW-1:0];

  // execute one command
  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    tgt_x_nxt = tgt_x_r;
    tgt_y_nxt = tgt_y_r;
    tool_nxt  = tool_r;
    accum_nxt = accum_r;
    res_push  = 1'b0;
    res       = '0;
    if (cmd_pop) begin
      unique case (cmd.act)
        vdcd_pkg::ACT_DX: tgt_x_nxt = tgt_x_r + sop;
        vdcd_pkg::ACT_DY: begin
          tgt_y_nxt = ty_sum;
          if (tool_r == vdcd_pkg::TOOL_NONE) begin
            pen_x_nxt = tgt_x_r;
            pen_y_nxt = ty_sum;
          end else if (tool_r == vdcd_pkg::TOOL_LINE) begin
            res_push         = 1'b1;
            res.draw_op      = vdcd_pkg::DOP_LINE;
            res.from_x       = ext_px[vdcd_pkg::OUT_CW-1:0];
            res.from_y       = ext_py[vdcd_pkg::OUT_CW-1:0];
            res.to_or_width  = ext_tx[vdcd_pkg::OUT_CW-1:0];
            res.to_or_height = ext_ty[vdcd_pkg::OUT_CW-1:0];
            pen_x_nxt        = tgt_x_r;
            pen_y_nxt        = ty_sum;
          end else if (tool_r == vdcd_pkg::TOOL_BLOCK) begin
            res_push         = 1'b1;
            res.draw_op      = vdcd_pkg::DOP_BLOCK;
            res.from_x       = ext_px[vdcd_pkg::OUT_CW-1:0];
            res.from_y       = ext_py[vdcd_pkg::OUT_CW-1:0];
            res.to_or_width  = ext_w[vdcd_pkg::OUT_CW-1:0];
            res.to_or_height = ext_h[vdcd_pkg::OUT_CW-1:0];
            pen_x_nxt        = tgt_x_r;
            pen_y_nxt        = ty_sum;
          end
        end
        vdcd_pkg::ACT_DATA: accum_nxt = {accum_r[DW-OW-1:0], cmd.opnd};
        vdcd_pkg::ACT_COLOUR: begin
          res_push    = 1'b1;
          res.draw_op = vdcd_pkg::DOP_COLOUR;
          res.value   = acc_value;
          accum_nxt   = '0;
        end
        vdcd_pkg::ACT_TGTX: begin
          tgt_x_nxt = acc_coord;
          accum_nxt = '0;
        end
        vdcd_pkg::ACT_TGTY: begin
          tgt_y_nxt = acc_coord;
          accum_nxt = '0;
        end
        vdcd_pkg::ACT_SHOW: begin
          res_push    = 1'b1;
          res.draw_op = vdcd_pkg::DOP_SHOW;
          accum_nxt   = '0;
        end
        vdcd_pkg::ACT_PAUSE: begin
          res_push    = 1'b1;
          res.draw_op = vdcd_pkg::DOP_PAUSE;
          res.value   = acc_value;
          accum_nxt   = '0;
        end
        vdcd_pkg::ACT_EOF: begin
          res_push    = 1'b1;
          res.draw_op = vdcd_pkg::DOP_EOF;
          accum_nxt   = '0;
        end
        vdcd_pkg::ACT_SELTOOL: begin
          tool_nxt  = cmd.opnd;
          accum_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // drawing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
      tgt_x_r <= '0;
      tgt_y_r <= '0;
      tool_r  <= vdcd_pkg::TOOL_LINE;
      accum_r <= '0;
    end else begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
      tgt_x_r <= tgt_x_nxt;
      tgt_y_r <= tgt_y_nxt;
      tool_r  <= tool_nxt;
      accum_r <= accum_nxt;
    end
  end

endmodule

// ----- rtl/vector_draw_command_decoder.sv -----
`timescale 1ns / 1ps
// Path: a byte passes the command queue and the back end; any draw word is held in the result queue.
// Throughput: one byte per cycle unless full; the back end executes one word a cycle unless stalled.
// Stalls: full rises when the command queue fills; the back end stops when
// the result queue is full.
// Reset: synchronous, active low; clears both queues, pen, target and data
// accumulator, and selects the line tool.
// ----------------------------------------------------------------------------
// vector_draw_command_decoder: byte-coded sketch stream interpreter
// Front end classifies command bytes into a short queue; the back end runs
// them against the drawing state and queues draw words for the consumer.
// ----------------------------------------------------------------------------
module vector_draw_command_decoder #(
  parameter int COORD_WIDTH     = 16,
  parameter int DATA_WIDTH      = 32,
  parameter int CMD_QUEUE_DEPTH = 4,
  parameter int RES_QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [vdcd_pkg::CMD_W-1:0]         in_cmd_byte,
  output logic                               empty,
  input  logic                               pop,
  output logic [2:0]                         out_draw_op,
  output logic signed [vdcd_pkg::OUT_CW-1:0] out_from_x,
  output logic signed [vdcd_pkg::OUT_CW-1:0] out_from_y,
  output logic signed [vdcd_pkg::OUT_CW-1:0] out_to_or_width,
  output logic signed [vdcd_pkg::OUT_CW-1:0] out_to_or_height,
  output logic [vdcd_pkg::OUT_VW-1:0]        out_value
);

  localparam int CMD_BITS = $bits(vdcd_pkg::cmd_t);
  localparam int RES_BITS = $bits(vdcd_pkg::res_t);

  vdcd_pkg::cmd_t front_word, back_word;
  vdcd_pkg::res_t back_res, head_res;
  logic           cq_push, cq_pop, cq_empty;
  logic           rq_push, rq_full;
  logic [CMD_BITS-1:0] cq_rd;
  logic [RES_BITS-1:0] rq_rd;

  // classify incoming bytes
  vdcd_front u_front (
    .push     (push),
    .q_full   (full),
    .cmd_byte (in_cmd_byte),
    .q_push   (cq_push),
    .q_word   (front_word)
  );

  // command queue between front and back
  vdcd_queue #(
    .W     (CMD_BITS),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cq_push),
    .wr_data (front_word),
    .rd_en   (cq_pop),
    .rd_data (cq_rd),
    .full    (full),
    .empty   (cq_empty)
  );

  assign back_word = vdcd_pkg::cmd_t'(cq_rd);

  // execute commands
  vdcd_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_word),
    .cmd_empty (cq_empty),
    .cmd_pop   (cq_pop),
    .res_full  (rq_full),
    .res_push  (rq_push),
    .res       (back_res)
  );

  // result queue toward the consumer
  vdcd_queue #(
    .W     (RES_BITS),
    .DEPTH (RES_QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rq_push),
    .wr_data (back_res),
    .rd_en   (pop),
    .rd_data (rq_rd),
    .full    (rq_full),
    .empty   (empty)
  );

  assign head_res         = vdcd_pkg::res_t'(rq_rd);
  assign out_draw_op      = head_res.draw_op;
  assign out_from_x       = head_res.from_x;
  assign out_from_y       = head_res.from_y;
  assign out_to_or_width  = head_res.to_or_width;
  assign out_to_or_height = head_res.to_or_height;
  assign out_value        = head_res.value;

endmodule
